/* src/cau_pkg.sv */
// cau_pkg: shared constants, operation codes and item types of the complex arithmetic unit
// no dependencies; imported by every other file of the block
package cau_pkg;

	localparam int WORD_BITS   = 32;
	localparam int FRAC_BITS   = 16;
	localparam int PROD_BITS   = 2 * WORD_BITS;
	localparam int SUM_BITS    = PROD_BITS + 2;
	localparam int QUO_BITS    = WORD_BITS + 1;
	localparam int REM_BITS    = PROD_BITS + QUO_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef logic signed [WORD_BITS-1:0] word_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_CONJ, OP_SCALE, OP_ABS2, OP_ABS
	} op_t;

	// per-item control, set once by the front end
	typedef struct packed {
		op_t  op;
		logic is_div;
		logic is_root;
		logic frac_shift;
	} ctl_t;

	typedef struct packed {
		ctl_t  ctl;
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t s;
	} cmd_t;

endpackage

/* src/cau_cmd_if.sv */
// cau_cmd_if: operand channel, valid/ready handshake with operation and operands
// depends on cau_pkg
interface cau_cmd_if import cau_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	word_t       x_real;
	word_t       x_imag;
	word_t       y_real;
	word_t       y_imag;
	word_t       scale_factor;

	modport source(output valid, operation, x_real, x_imag, y_real, y_imag, scale_factor,
		input ready);
	modport sink(input valid, operation, x_real, x_imag, y_real, y_imag, scale_factor,
		output ready);
endinterface

/* src/cau_res_if.sv */
// cau_res_if: result channel, valid/ready handshake with complex result and flags
// depends on cau_pkg
interface cau_res_if import cau_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t z_real;
	word_t z_imag;
	logic  saturated;
	logic  divide_by_zero;

	modport source(output valid, z_real, z_imag, saturated, divide_by_zero, input ready);
	modport sink(input valid, z_real, z_imag, saturated, divide_by_zero, output ready);
endinterface

/* src/cau_front.sv */
// cau_front: accepts operand items, decodes the operation, hands items to the queue
// depends on cau_pkg and cau_cmd_if
module cau_front import cau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cau_cmd_if.sink cmd,
	input  logic q_full,
	output logic push,
	output cmd_t push_data
);

	cmd_t dec;
	cmd_t ent_s1;
	logic v_s1;
	logic take;

	always_comb begin
		dec.ctl.op         = op_t'(cmd.operation);
		dec.ctl.is_div     = (dec.ctl.op == OP_DIV);
		dec.ctl.is_root    = (dec.ctl.op == OP_ABS);
		dec.ctl.frac_shift = (dec.ctl.op inside {OP_MULT, OP_SCALE, OP_ABS2});
		dec.a              = cmd.x_real;
		dec.b              = cmd.x_imag;
		dec.c              = cmd.y_real;
		dec.d              = cmd.y_imag;
		dec.s              = cmd.scale_factor;
	end

	assign push      = v_s1 && !q_full;
	assign cmd.ready = !v_s1 || !q_full;
	assign take      = cmd.valid && cmd.ready;
	assign push_data = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_s1 <= dec;
		end
	end

endmodule

/* src/cau_queue.sv */
// cau_queue: short item queue between front end and execution pipeline
// depends on cau_pkg
module cau_queue import cau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

/* src/cau_back.sv */
// cau_back: execution pipeline, products, sums, pipelined divide/root lanes, saturation
// depends on cau_pkg and cau_res_if
module cau_back import cau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic empty,
	output logic pop,
	cau_res_if.source res
);

	localparam int STEPS = QUO_BITS;

	typedef logic signed [SUM_BITS-1:0] sum_t;
	typedef logic [REM_BITS-1:0]        rem_t;
	typedef logic [QUO_BITS-1:0]        quo_t;

	typedef struct packed {
		word_t val;
		logic  sat;
	} clip_t;

	typedef struct packed {
		ctl_t                 ctl;
		logic [PROD_BITS-1:0] den;
		rem_t                 rem_r;
		rem_t                 rem_i;
		quo_t                 quo_r;
		quo_t                 quo_i;
		logic                 neg_r;
		logic                 neg_i;
		logic                 ovf_r;
		logic                 ovf_i;
		logic                 dz;
		logic                 neg_a;
		logic                 neg_b;
		word_t                early_r;
		word_t                early_i;
		logic                 early_sat;
	} lane_t;

	function automatic clip_t clip_word(input sum_t v);
		clip_t r;
		sum_t  hi;
		sum_t  lo;
		hi    = SUM_BITS'(WORD_MAX);
		lo    = SUM_BITS'(WORD_MIN);
		r.sat = 1'b1;
		if (v > hi) begin
			r.val = WORD_MAX;
		end else if (v < lo) begin
			r.val = WORD_MIN;
		end else begin
			r.val = v[WORD_BITS-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// drop fraction bits, rounding toward zero
	function automatic sum_t trunc_frac(input sum_t v);
		sum_t bias;
		bias = v[SUM_BITS-1] ? sum_t'({{(SUM_BITS-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}}) : '0;
		return (v + bias) >>> FRAC_BITS;
	endfunction

	function automatic clip_t quo_clip(input quo_t q, input logic neg, input logic ovf);
		clip_t r;
		sum_t  v;
		v = SUM_BITS'(q);
		if (neg) begin
			v = -v;
		end
		r = clip_word(v);
		if (ovf) begin
			r.sat = 1'b1;
			r.val = neg ? WORD_MIN : WORD_MAX;
		end
		return r;
	endfunction

	// one quotient/root bit per lane: compare and subtract
	function automatic lane_t lane_step(input lane_t l, input int k);
		lane_t n;
		rem_t  tr;
		rem_t  ti;
		n  = l;
		ti = REM_BITS'(l.den) << k;
		tr = l.ctl.is_root ? ((REM_BITS'(l.quo_r) << (k + 1)) | (REM_BITS'(1'b1) << (2 * k)))
			: ti;
		if (l.rem_r >= tr) begin
			n.rem_r = l.rem_r - tr;
			n.quo_r = l.quo_r | (QUO_BITS'(1'b1) << k);
		end
		if (l.rem_i >= ti) begin
			n.rem_i = l.rem_i - ti;
			n.quo_i = l.quo_i | (QUO_BITS'(1'b1) << k);
		end
		return n;
	endfunction

	logic adv;

	// stage 1: operand select and products
	logic                        v_s1;
	ctl_t                        ctl_s1;
	logic                        neg_a_s1;
	logic                        neg_b_s1;
	logic signed [WORD_BITS:0]   lin_r_s1;
	logic signed [WORD_BITS:0]   lin_i_s1;
	logic signed [PROD_BITS-1:0] prod_s1 [6];
	word_t                       y0;
	word_t                       y1;
	logic signed [WORD_BITS:0]   lr;
	logic signed [WORD_BITS:0]   li;

	// stage 2: sums
	logic                 v_s2;
	ctl_t                 ctl_s2;
	logic                 neg_a_s2;
	logic                 neg_b_s2;
	sum_t                 sum_r_s2;
	sum_t                 sum_i_s2;
	logic [PROD_BITS-1:0] den_s2;
	sum_t                 sr;
	sum_t                 si;

	// stage 3 onward: lanes
	lane_t                lane_q [STEPS+1];
	logic                 lane_vld_q [STEPS+1];
	lane_t                init;
	lane_t                fin;
	logic [SUM_BITS-1:0]  mag_r;
	logic [SUM_BITS-1:0]  mag_i;
	clip_t                cr;
	clip_t                ci;
	clip_t                qr;
	clip_t                qi;

	// output register
	logic  out_v_q;
	word_t z_r_q;
	word_t z_i_q;
	logic  sat_q;
	logic  dz_q;
	word_t zr;
	word_t zi;
	logic  sat;
	logic  dz;

	assign adv = !out_v_q || res.ready;
	assign pop = adv && !empty;

	always_comb begin
		y0 = head.c;
		y1 = head.d;
		case (head.ctl.op)
			OP_SCALE: begin
				y0 = head.s;
				y1 = head.s;
			end
			OP_ABS2, OP_ABS: begin
				y0 = head.a;
				y1 = head.b;
			end
			default: ;
		endcase
	end

	always_comb begin
		lr = (WORD_BITS+1)'(head.a) + (WORD_BITS+1)'(head.c);
		li = (WORD_BITS+1)'(head.b) + (WORD_BITS+1)'(head.d);
		case (head.ctl.op)
			OP_SUB: begin
				lr = (WORD_BITS+1)'(head.a) - (WORD_BITS+1)'(head.c);
				li = (WORD_BITS+1)'(head.b) - (WORD_BITS+1)'(head.d);
			end
			OP_CONJ: begin
				lr = (WORD_BITS+1)'(head.a);
				li = -((WORD_BITS+1)'(head.b));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1     <= head.ctl;
			neg_a_s1   <= head.a[WORD_BITS-1];
			neg_b_s1   <= head.b[WORD_BITS-1];
			lin_r_s1   <= lr;
			lin_i_s1   <= li;
			prod_s1[0] <= PROD_BITS'(head.a) * PROD_BITS'(y0);
			prod_s1[1] <= PROD_BITS'(head.b) * PROD_BITS'(y1);
			prod_s1[2] <= PROD_BITS'(head.a) * PROD_BITS'(head.d);
			prod_s1[3] <= PROD_BITS'(head.b) * PROD_BITS'(head.c);
			prod_s1[4] <= PROD_BITS'(head.c) * PROD_BITS'(head.c);
			prod_s1[5] <= PROD_BITS'(head.d) * PROD_BITS'(head.d);
		end
	end

	always_comb begin
		case (ctl_s1.op)
			OP_MULT: begin
				sr = SUM_BITS'(prod_s1[0]) - SUM_BITS'(prod_s1[1]);
				si = SUM_BITS'(prod_s1[2]) + SUM_BITS'(prod_s1[3]);
			end
			OP_DIV: begin
				sr = SUM_BITS'(prod_s1[0]) + SUM_BITS'(prod_s1[1]);
				si = SUM_BITS'(prod_s1[3]) - SUM_BITS'(prod_s1[2]);
			end
			OP_SCALE: begin
				sr = SUM_BITS'(prod_s1[0]);
				si = SUM_BITS'(prod_s1[1]);
			end
			OP_ABS2, OP_ABS: begin
				sr = SUM_BITS'(prod_s1[0]) + SUM_BITS'(prod_s1[1]);
				si = '0;
			end
			default: begin
				sr = SUM_BITS'(lin_r_s1);
				si = SUM_BITS'(lin_i_s1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2   <= ctl_s1;
			neg_a_s2 <= neg_a_s1;
			neg_b_s2 <= neg_b_s1;
			sum_r_s2 <= sr;
			sum_i_s2 <= si;
			den_s2   <= $unsigned(prod_s1[4]) + $unsigned(prod_s1[5]);
		end
	end

	// lane setup and the finished results of the simple operations
	always_comb begin
		mag_r = $unsigned(sum_r_s2[SUM_BITS-1] ? -sum_r_s2 : sum_r_s2);
		mag_i = $unsigned(sum_i_s2[SUM_BITS-1] ? -sum_i_s2 : sum_i_s2);
		cr    = clip_word(ctl_s2.frac_shift ? trunc_frac(sum_r_s2) : sum_r_s2);
		ci    = clip_word(ctl_s2.frac_shift ? trunc_frac(sum_i_s2) : sum_i_s2);

		init.ctl       = ctl_s2;
		init.den       = den_s2;
		init.rem_r     = ctl_s2.is_root ? REM_BITS'(mag_r) : (REM_BITS'(mag_r) << FRAC_BITS);
		init.rem_i     = REM_BITS'(mag_i) << FRAC_BITS;
		init.quo_r     = '0;
		init.quo_i     = '0;
		init.neg_r     = sum_r_s2[SUM_BITS-1];
		init.neg_i     = sum_i_s2[SUM_BITS-1];
		// the root lane has no divisor, its quotient never overflows
		init.ovf_r     = !ctl_s2.is_root && (init.rem_r >= (REM_BITS'(den_s2) << QUO_BITS));
		init.ovf_i     = (init.rem_i >= (REM_BITS'(den_s2) << QUO_BITS));
		init.dz        = (den_s2 == '0);
		init.neg_a     = neg_a_s2;
		init.neg_b     = neg_b_s2;
		init.early_r   = cr.val;
		init.early_i   = ci.val;
		init.early_sat = cr.sat | ci.sat;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_q[0] <= init;
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = STEPS - 1 - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lane_vld_q[j+1] <= 1'b0;
			end else if (adv) begin
				lane_vld_q[j+1] <= lane_vld_q[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lane_q[j+1] <= lane_step(lane_q[j], K);
			end
		end
	end

	assign fin = lane_q[STEPS];

	always_comb begin
		qr  = quo_clip(fin.quo_r, fin.neg_r, fin.ovf_r);
		qi  = quo_clip(fin.quo_i, fin.neg_i, fin.ovf_i);
		zr  = fin.early_r;
		zi  = fin.early_i;
		sat = fin.early_sat;
		dz  = 1'b0;
		if (fin.ctl.is_div) begin
			if (fin.dz) begin
				zr  = fin.neg_a ? WORD_MIN : WORD_MAX;
				zi  = fin.neg_b ? WORD_MIN : WORD_MAX;
				sat = 1'b1;
				dz  = 1'b1;
			end else begin
				zr  = qr.val;
				zi  = qi.val;
				sat = qr.sat | qi.sat;
			end
		end else if (fin.ctl.is_root) begin
			zr  = qr.val;
			zi  = '0;
			sat = qr.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			lane_vld_q[0] <= 1'b0;
			out_v_q       <= 1'b0;
		end else if (adv) begin
			v_s1          <= !empty;
			v_s2          <= v_s1;
			lane_vld_q[0] <= v_s2;
			out_v_q       <= lane_vld_q[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_r_q <= zr;
			z_i_q <= zi;
			sat_q <= sat;
			dz_q  <= dz;
		end
	end

	assign res.valid          = out_v_q;
	assign res.z_real         = z_r_q;
	assign res.z_imag         = z_i_q;
	assign res.saturated      = sat_q;
	assign res.divide_by_zero = dz_q;

endmodule

/* src/complex_arithmetic_unit.sv */
// complex_arithmetic_unit: top level of the Q16.16 complex ALU
// depends on cau_pkg, cau_cmd_if, cau_res_if, cau_front, cau_queue, cau_back
//
//   channel  dir    handshake     payload
//   cmd      sink   valid/ready   operation, x_real, x_imag, y_real, y_imag, scale_factor
//   res      source valid/ready   z_real, z_imag, saturated, divide_by_zero
//
// one item per cycle sustained while res is ready; every operation takes the same path, so results
// leave in order
// the depth is set by the divide/root lanes: one quotient or root bit per stage, 33 stages
// reset clears only valid bits, pointers and counts; the block takes items right after reset
// a stall on res freezes the execution pipeline; the 4-entry queue and the front register
// keep taking items until the queue fills
module complex_arithmetic_unit import cau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cau_cmd_if.sink   cmd,
	cau_res_if.source res
);

	// front end to queue
	logic push;
	cmd_t push_data;
	logic q_full;

	// queue to execution pipeline
	logic pop;
	cmd_t head;
	logic q_empty;

	// decode and hold one item
	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// decouples intake from the execution pipeline stalls
	cau_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	// products, sums, divide and root lanes, saturation, output register
	cau_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.res    (res)
	);

endmodule
